// ===== sv/mmq_pkg.sv =====
package mmq_pkg;

    localparam int WORD_W = 32;
    localparam int DIM_W = 3;
    localparam int IDX_W = 2;
    localparam int ADDR_W = 4;
    localparam int SIDE_CAP = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [DIM_W-1:0] DIM_RESET = 3'd4;

    localparam logic [1:0] CMD_WRITE_A = 2'd0;
    localparam logic [1:0] CMD_WRITE_B = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    localparam logic [1:0] REG_ROWS_A = 2'd0;
    localparam logic [1:0] REG_INNER_DIM = 2'd1;
    localparam logic [1:0] REG_COLS_B = 2'd2;

    typedef struct packed {
        logic              is_compute;
        logic              is_b;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [WORD_W-1:0] value;
    } q_item_t;

    typedef struct packed {
        logic [DIM_W-1:0] rows_a;
        logic [DIM_W-1:0] inner_dim;
        logic [DIM_W-1:0] cols_b;
    } dims_t;

endpackage

// ===== sv/mmq_ram.sv =====
module mmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mmq_front.sv =====
module mmq_front #(
    parameter int DIM = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mmq_pkg::ADDR_W-1:0] paddr,
    input  logic [mmq_pkg::WORD_W-1:0] pwdata,
    output logic [mmq_pkg::WORD_W-1:0] prdata,
    output logic                       pready,
    input  logic                       start,
    input  logic                       full,
    output logic                       busy,
    input  logic [1:0]                 cmd,
    input  logic [mmq_pkg::IDX_W-1:0]  row,
    input  logic [mmq_pkg::IDX_W-1:0]  col,
    input  logic [mmq_pkg::WORD_W-1:0] value,
    output logic                       push,
    output mmq_pkg::q_item_t           push_item,
    output mmq_pkg::dims_t             dims
);

    localparam int LIM = (DIM < mmq_pkg::SIDE_CAP) ? DIM : mmq_pkg::SIDE_CAP;

    logic [mmq_pkg::DIM_W-1:0] rows_a_reg;
    logic [mmq_pkg::DIM_W-1:0] inner_dim_reg;
    logic [mmq_pkg::DIM_W-1:0] cols_b_reg;
    logic [1:0]                reg_idx;
    logic                      cfg_write;
    logic                      accept;
    logic                      in_range;
    logic                      is_write;

    function automatic logic [mmq_pkg::DIM_W-1:0] clamp_dim(input logic [mmq_pkg::DIM_W-1:0] v);
        logic [mmq_pkg::DIM_W-1:0] r;
        r = v;
        if (int'(v) > LIM)
        begin
            r = mmq_pkg::DIM_W'(LIM);
        end
        return r;
    endfunction

    assign reg_idx = paddr[mmq_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg <= mmq_pkg::DIM_RESET;
            inner_dim_reg <= mmq_pkg::DIM_RESET;
            cols_b_reg <= mmq_pkg::DIM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                mmq_pkg::REG_ROWS_A:    rows_a_reg <= pwdata[mmq_pkg::DIM_W-1:0];
                mmq_pkg::REG_INNER_DIM: inner_dim_reg <= pwdata[mmq_pkg::DIM_W-1:0];
                mmq_pkg::REG_COLS_B:    cols_b_reg <= pwdata[mmq_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            mmq_pkg::REG_ROWS_A:    prdata = mmq_pkg::WORD_W'(rows_a_reg);
            mmq_pkg::REG_INNER_DIM: prdata = mmq_pkg::WORD_W'(inner_dim_reg);
            mmq_pkg::REG_COLS_B:    prdata = mmq_pkg::WORD_W'(cols_b_reg);
            default:                prdata = '0;
        endcase
    end

    assign dims.rows_a = clamp_dim(rows_a_reg);
    assign dims.inner_dim = clamp_dim(inner_dim_reg);
    assign dims.cols_b = clamp_dim(cols_b_reg);

    // unused command and writes outside the store never reach the queue
    assign busy = full;
    assign accept = start && !full;
    assign in_range = (int'(row) < DIM) && (int'(col) < DIM);
    assign is_write = (cmd == mmq_pkg::CMD_WRITE_A) || (cmd == mmq_pkg::CMD_WRITE_B);
    assign push = accept && ((cmd == mmq_pkg::CMD_COMPUTE) || (is_write && in_range));

    assign push_item.is_compute = (cmd == mmq_pkg::CMD_COMPUTE);
    assign push_item.is_b = (cmd == mmq_pkg::CMD_WRITE_B);
    assign push_item.row = row;
    assign push_item.col = col;
    assign push_item.value = value;

endmodule

// ===== sv/mmq_queue.sv =====
module mmq_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mmq_pkg::q_item_t push_item,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output mmq_pkg::q_item_t item
);

    localparam int PW = (mmq_pkg::QUEUE_DEPTH > 1) ? $clog2(mmq_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(mmq_pkg::QUEUE_DEPTH + 1);

    mmq_pkg::q_item_t mem_reg [mmq_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    assign full = (count_reg == CW'(mmq_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(mmq_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(mmq_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> valid)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(mmq_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== sv/mmq_back.sv =====
module mmq_back #(
    parameter int DIM = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mmq_pkg::dims_t             dims,
    input  logic                       q_valid,
    input  mmq_pkg::q_item_t           q_item,
    output logic                       pop,
    output logic                       strobe,
    output logic [mmq_pkg::IDX_W-1:0]  out_row,
    output logic [mmq_pkg::IDX_W-1:0]  out_col,
    output logic [mmq_pkg::WORD_W-1:0] product_value,
    output logic                       last
);

    localparam int AW = $clog2(DIM * DIM);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN = 1'b1;

    typedef struct packed {
        logic                      first;
        logic                      lastterm;
        logic                      zero;
        logic [mmq_pkg::IDX_W-1:0] row;
        logic [mmq_pkg::IDX_W-1:0] col;
        logic                      last;
    } tag_t;

    logic                       state_reg;
    logic                       state_next;
    logic [mmq_pkg::IDX_W-1:0]  i_reg;
    logic [mmq_pkg::IDX_W-1:0]  i_next;
    logic [mmq_pkg::IDX_W-1:0]  k_reg;
    logic [mmq_pkg::IDX_W-1:0]  k_next;
    logic [mmq_pkg::IDX_W-1:0]  j_reg;
    logic [mmq_pkg::IDX_W-1:0]  j_next;
    logic                       issue;
    logic                       nk_zero;
    logic                       j_end;
    logic                       k_end;
    logic                       i_end;
    logic                       start_run;
    tag_t                       issue_tag;
    logic                       we_a;
    logic                       we_b;
    logic [AW-1:0]              waddr;
    logic [AW-1:0]              raddr_a;
    logic [AW-1:0]              raddr_b;
    logic [mmq_pkg::WORD_W-1:0] rdata_a;
    logic [mmq_pkg::WORD_W-1:0] rdata_b;
    logic signed [63:0]         full_prod;
    logic                       s1_valid_reg;
    tag_t                       s1_tag_reg;
    logic                       s2_valid_reg;
    tag_t                       s2_tag_reg;
    logic [mmq_pkg::WORD_W-1:0] s2_prod_reg;
    logic [mmq_pkg::WORD_W-1:0] acc_reg;
    logic [mmq_pkg::WORD_W-1:0] sum;
    logic                       strobe_reg;
    logic [mmq_pkg::IDX_W-1:0]  out_row_reg;
    logic [mmq_pkg::IDX_W-1:0]  out_col_reg;
    logic [mmq_pkg::WORD_W-1:0] product_value_reg;
    logic                       last_reg;

    // writes are applied only between multiplies, so item order is kept
    assign pop = q_valid && (state_reg == ST_IDLE);
    assign we_a = pop && !q_item.is_compute && !q_item.is_b;
    assign we_b = pop && !q_item.is_compute && q_item.is_b;
    assign waddr = AW'(int'(q_item.row) * DIM + int'(q_item.col));
    assign start_run = pop && q_item.is_compute && (dims.rows_a != '0) && (dims.cols_b != '0);

    assign issue = (state_reg == ST_RUN);
    assign nk_zero = (dims.inner_dim == '0);
    assign j_end = nk_zero || (({1'b0, j_reg} + 3'd1) == dims.inner_dim);
    assign k_end = (({1'b0, k_reg} + 3'd1) == dims.cols_b);
    assign i_end = (({1'b0, i_reg} + 3'd1) == dims.rows_a);

    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg;
        k_next = k_reg;
        j_next = j_reg;
        if (start_run)
        begin
            state_next = ST_RUN;
            i_next = '0;
            k_next = '0;
            j_next = '0;
        end
        else if (issue)
        begin
            if (!j_end)
            begin
                j_next = j_reg + 1'b1;
            end
            else
            begin
                j_next = '0;
                if (!k_end)
                begin
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    k_next = '0;
                    if (!i_end)
                    begin
                        i_next = i_reg + 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg <= '0;
            k_reg <= '0;
            j_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg <= i_next;
            k_reg <= k_next;
            j_reg <= j_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            strobe_reg <= s2_valid_reg && s2_tag_reg.lastterm;
        end
    end

    assign issue_tag.first = (j_reg == '0);
    assign issue_tag.lastterm = j_end;
    assign issue_tag.zero = nk_zero;
    assign issue_tag.row = i_reg;
    assign issue_tag.col = k_reg;
    assign issue_tag.last = i_end && k_end;

    assign raddr_a = AW'(int'(i_reg) * DIM + int'(j_reg));
    assign raddr_b = AW'(int'(j_reg) * DIM + int'(k_reg));

    mmq_ram #(
        .WIDTH(mmq_pkg::WORD_W),
        .DEPTH(DIM * DIM)
    ) u_ram_a (
        .clk(clk),
        .we(we_a),
        .waddr(waddr),
        .wdata(q_item.value),
        .raddr(raddr_a),
        .rdata(rdata_a)
    );

    mmq_ram #(
        .WIDTH(mmq_pkg::WORD_W),
        .DEPTH(DIM * DIM)
    ) u_ram_b (
        .clk(clk),
        .we(we_b),
        .waddr(waddr),
        .wdata(q_item.value),
        .raddr(raddr_b),
        .rdata(rdata_b)
    );

    assign full_prod = $signed(rdata_a) * $signed(rdata_b);
    // dropping the low fraction bits of the signed product is the arithmetic shift
    assign sum = (s2_tag_reg.first ? '0 : acc_reg) + s2_prod_reg;

    always_ff @(posedge clk)
    begin
        s1_tag_reg <= issue_tag;
        s2_tag_reg <= s1_tag_reg;
        s2_prod_reg <= s1_tag_reg.zero ? '0 : full_prod[FRAC_BITS +: mmq_pkg::WORD_W];
        if (s2_valid_reg)
        begin
            acc_reg <= sum;
        end
        if (s2_valid_reg && s2_tag_reg.lastterm)
        begin
            out_row_reg <= s2_tag_reg.row;
            out_col_reg <= s2_tag_reg.col;
            product_value_reg <= sum;
            last_reg <= s2_tag_reg.last;
        end
    end

    assign strobe = strobe_reg;
    assign out_row = out_row_reg;
    assign out_col = out_col_reg;
    assign product_value = product_value_reg;
    assign last = last_reg;

    assert property (@(posedge clk) disable iff (!rst_n) issue |=> s1_valid_reg)
        else $error("issued term lost before operand stage");
    assert property (@(posedge clk) disable iff (!rst_n) issue |-> !pop)
        else $error("queue popped while multiply in flight");
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_tag_reg.lastterm && s1_tag_reg.last |=> ##1 strobe && last)
        else $error("final element not flagged on output");

endmodule

// ===== sv/q16_matrix_multiply_4x4.sv =====
// with the back end idle, a taken start passes the queue, the issue state, the RAM read
// and product registers and the output register before the first word's strobe rises;
// later words follow as their sums finish; a write holds the back end only for its pop,
// a multiply until its last term issues, at one term per cycle through the multiplier
// a two-entry queue lets new items be taken while a multiply runs; busy means it is full;
// results leave on strobe for one cycle each; the receiver cannot stall them
// rst_n clears control and sets every dimension register to 4; matrix stores stay as they are
module q16_matrix_multiply_4x4 #(
    parameter int DIM = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [mmq_pkg::ADDR_W-1:0] paddr,
    input  logic [mmq_pkg::WORD_W-1:0] pwdata,
    output logic [mmq_pkg::WORD_W-1:0] prdata,
    output logic                       pready,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 cmd,
    input  logic [mmq_pkg::IDX_W-1:0]  row,
    input  logic [mmq_pkg::IDX_W-1:0]  col,
    input  logic [mmq_pkg::WORD_W-1:0] value,
    output logic                       strobe,
    output logic [mmq_pkg::IDX_W-1:0]  out_row,
    output logic [mmq_pkg::IDX_W-1:0]  out_col,
    output logic [mmq_pkg::WORD_W-1:0] product_value,
    output logic                       last
);

    logic             push;
    mmq_pkg::q_item_t push_item;
    logic             full;
    logic             pop;
    logic             q_valid;
    mmq_pkg::q_item_t q_item;
    mmq_pkg::dims_t   dims;

    mmq_front #(
        .DIM(DIM)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .start(start),
        .full(full),
        .busy(busy),
        .cmd(cmd),
        .row(row),
        .col(col),
        .value(value),
        .push(push),
        .push_item(push_item),
        .dims(dims)
    );

    mmq_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_item(push_item),
        .full(full),
        .pop(pop),
        .valid(q_valid),
        .item(q_item)
    );

    mmq_back #(
        .DIM(DIM),
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .dims(dims),
        .q_valid(q_valid),
        .q_item(q_item),
        .pop(pop),
        .strobe(strobe),
        .out_row(out_row),
        .out_col(out_col),
        .product_value(product_value),
        .last(last)
    );

endmodule
